### design/sorted_integer_set_assert.svh
// Assertion macros shared by the sorted integer set modules.
`ifndef SORTED_INTEGER_SET_ASSERT_SVH
`define SORTED_INTEGER_SET_ASSERT_SVH

`ifndef SYNTHESIS
`define SIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted_integer_set: implication check failed");
`define SIS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sorted_integer_set: invariant check failed");
`else
`define SIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif

`endif

### design/sis_pkg.sv
// Types, codes and helpers for the sorted integer set.
`default_nettype none

package sis_pkg;

	localparam int unsigned CAPACITY_DEF = 256;

	typedef logic signed [63:0] value_t;
	typedef logic [1:0]         cmd_t;
	typedef logic [1:0]         wclass_t;
	typedef logic [8:0]         pos_t;

	localparam cmd_t CMD_ADD    = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_FIND   = 2'd2;

	localparam wclass_t WCLASS_16 = 2'd0;
	localparam wclass_t WCLASS_32 = 2'd1;
	localparam wclass_t WCLASS_64 = 2'd2;

	typedef struct packed {
		logic    present;
		pos_t    position;
		logic    status;
		pos_t    count;
		wclass_t width_class;
	} rsp_t;

	// Finished result from the controller, and the handoff to the output stage.
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} done_t;

	// Narrowest class whose sign extension reproduces v.
	function automatic wclass_t class_of(value_t v);
		if (&v[63:15] || ~|v[63:15])
			return WCLASS_16;
		if (&v[63:31] || ~|v[63:31])
			return WCLASS_32;
		return WCLASS_64;
	endfunction

endpackage

`default_nettype wire

### design/sis_if.sv
// Request and response channel interfaces of the sorted integer set.
`default_nettype none

interface sis_req_if;
	logic             valid;
	logic             ready;
	sis_pkg::cmd_t    command;
	sis_pkg::value_t  value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface sis_rsp_if;
	logic              valid;
	logic              ready;
	logic              present;
	sis_pkg::pos_t     position;
	logic              status;
	sis_pkg::pos_t     count;
	sis_pkg::wclass_t  width_class;

	modport source (output valid, output present, output position, output status,
		output count, output width_class, input ready);
	modport sink   (input valid, input present, input position, input status,
		input count, input width_class, output ready);
endinterface

`default_nettype wire

### design/sis_store.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
`include "sorted_integer_set_assert.svh"

module sis_store #(
	parameter int unsigned DEPTH = sis_pkg::CAPACITY_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire sis_pkg::value_t              wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output sis_pkg::value_t                   rdata
);

	sis_pkg::value_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

	// The shift schedule never reads the entry it writes in the same cycle.
	`SIS_ASSERT_IMP(a_no_rw_collision, clk, arst_n, re && we, raddr != waddr)

endmodule

`default_nettype wire

### design/sis_ctrl.sv
// Search and shift sequencer around the entry memory.
`default_nettype none
`include "sorted_integer_set_assert.svh"

module sis_ctrl #(
	parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire sis_pkg::cmd_t     req_command,
	input  wire sis_pkg::value_t   req_value,
	output sis_pkg::done_t         done,
	input  wire logic              take
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_SRCH   = 8'b00000010,
		S_CMP    = 8'b00000100,
		S_DECIDE = 8'b00001000,
		S_UP     = 8'b00010000,
		S_PUT    = 8'b00100000,
		S_DOWN   = 8'b01000000,
		S_DONE   = 8'b10000000
	} state_t;

	state_t            state_q;
	sis_pkg::cmd_t     cmd_q;
	sis_pkg::value_t   value_q;
	logic [CW-1:0]     lo_q, hi_q, mid_q, pos_q, ptr_q, count_q;
	logic              found_q, status_q;
	sis_pkg::wclass_t  class_q;
	logic              wr_s1;
	logic [AW-1:0]     wr_addr_s1;

	logic [CW:0]       sum;
	logic [CW-1:0]     mid;
	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	sis_pkg::value_t   wdata, rdata;
	sis_pkg::wclass_t  new_class;

	assign sum       = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = sum[CW:1];
	assign new_class = sis_pkg::class_of(value_q);
	assign req_ready = (state_q == S_IDLE);

	sis_store #(.DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Memory port steering.
	always_comb begin
		we    = 1'b0;
		waddr = wr_addr_s1;
		wdata = rdata;
		re    = 1'b0;
		raddr = mid[AW-1:0];
		unique case (state_q)
			S_SRCH: begin
				re    = (lo_q < hi_q);
				raddr = mid[AW-1:0];
			end
			S_UP: begin
				we = wr_s1;
				re = (ptr_q != pos_q);
				raddr = AW'(ptr_q - CW'(1));
			end
			S_DOWN: begin
				we = wr_s1;
				re = (ptr_q < count_q);
				raddr = ptr_q[AW-1:0];
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = value_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			class_q <= sis_pkg::WCLASS_16;
			wr_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						lo_q     <= '0;
						hi_q     <= count_q;
						found_q  <= 1'b0;
						status_q <= 1'b0;
						state_q  <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else begin
						pos_q   <= lo_q;
						state_q <= S_DECIDE;
					end
				end
				S_CMP: begin
					if (rdata == value_q) begin
						found_q <= 1'b1;
						pos_q   <= mid_q;
						state_q <= S_DECIDE;
					end else begin
						if (rdata < value_q)
							lo_q <= mid_q + CW'(1);
						else
							hi_q <= mid_q;
						state_q <= S_SRCH;
					end
				end
				S_DECIDE: begin
					wr_s1 <= 1'b0;
					if (cmd_q == sis_pkg::CMD_ADD && !found_q) begin
						if (count_q == CW'(CAPACITY)) begin
							status_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							ptr_q   <= count_q;
							state_q <= S_UP;
						end
					end else if (cmd_q == sis_pkg::CMD_REMOVE && found_q) begin
						ptr_q   <= pos_q + CW'(1);
						state_q <= S_DOWN;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Read entry ptr-1 now, write it to ptr next cycle.
				S_UP: begin
					if (ptr_q != pos_q) begin
						wr_s1      <= 1'b1;
						wr_addr_s1 <= ptr_q[AW-1:0];
						ptr_q      <= ptr_q - CW'(1);
					end else begin
						wr_s1   <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					if (new_class > class_q)
						class_q <= new_class;
					state_q <= S_DONE;
				end
				// Read entry ptr now, write it to ptr-1 next cycle.
				S_DOWN: begin
					if (ptr_q < count_q) begin
						wr_s1      <= 1'b1;
						wr_addr_s1 <= AW'(ptr_q - CW'(1));
						ptr_q      <= ptr_q + CW'(1);
					end else begin
						wr_s1   <= 1'b0;
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1))
							class_q <= sis_pkg::WCLASS_16;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload holds no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q   <= req_command;
			value_q <= req_value;
		end
	end

	always_comb begin
		done.valid           = (state_q == S_DONE);
		done.rsp.present     = found_q;
		done.rsp.position    = sis_pkg::pos_t'(pos_q);
		done.rsp.status      = status_q;
		done.rsp.count       = sis_pkg::pos_t'(count_q);
		done.rsp.width_class = class_q;
	end

	`SIS_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CW'(CAPACITY))
	`SIS_ASSERT_IMP(a_empty_is_narrow, clk, arst_n, count_q == '0,
		class_q == sis_pkg::WCLASS_16)
	`SIS_ASSERT_IMP(a_bounds_ordered, clk, arst_n, state_q == S_SRCH, lo_q <= hi_q)
	`SIS_ASSERT_IMP(a_write_only_when_shifting, clk, arst_n, we,
		state_q == S_UP || state_q == S_DOWN || state_q == S_PUT)
	`SIS_ASSERT_IMP(a_count_moves_by_one, clk, arst_n, state_q != S_PUT && state_q != S_DOWN,
		count_q == $past(count_q) || $past(state_q) == S_PUT || $past(state_q) == S_DOWN)

endmodule

`default_nettype wire

### design/sorted_integer_set.sv
// Sorted integer set: top level with request intake and response register.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   command, value
//   rsp      out  valid/ready   present, position, status, count, width_class
//
// One request at a time. Each binary search probe passes through a search state and a
// compare state, and a decision state follows; an add of a new value then shifts the
// entries from its position up and writes it, a remove shifts the entries above it
// down, through the single memory port pair. Reset clears the state, count, class
// and response valid flag, not the entries; entries above count are never read.
// The response register frees the sequencer while a result waits on rsp;
// the sequencer stalls in its done state only while that register is still full.
`default_nettype none

module sorted_integer_set #(
	parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sis_req_if.sink    req,
	sis_rsp_if.source  rsp
);

	sis_pkg::done_t  done;
	logic            take;
	logic            out_valid_q;
	sis_pkg::rsp_t   out_q;

	assign take = done.valid && (!out_valid_q || rsp.ready);

	sis_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_command(req.command),
		.req_value  (req.value),
		.done       (done),
		.take       (take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= done.rsp;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.present     = out_q.present;
	assign rsp.position    = out_q.position;
	assign rsp.status      = out_q.status;
	assign rsp.count       = out_q.count;
	assign rsp.width_class = out_q.width_class;

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the sorted integer set: directed table, random mix, full store.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned SET_CAPACITY = sis_pkg::CAPACITY_DEF;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam sis_pkg::cmd_t CMD_UNUSED = 2'd3;

	localparam sis_pkg::value_t V_I16_MAX = 64'sd32767;
	localparam sis_pkg::value_t V_I16_MIN = -64'sd32768;
	localparam sis_pkg::value_t V_I32_MAX = 64'sd2147483647;
	localparam sis_pkg::value_t V_I32_MIN = -64'sd2147483648;
	localparam sis_pkg::value_t V_I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam sis_pkg::value_t V_I64_MIN = 64'sh8000_0000_0000_0000;

	logic clk;
	logic arst_n;

	sis_req_if req_ch ();
	sis_rsp_if rsp_ch ();

	sorted_integer_set u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the set
	sis_pkg::value_t  member_vals [SET_CAPACITY];
	int unsigned      member_count;
	sis_pkg::wclass_t member_class;

	sis_pkg::rsp_t pending_rsp_q [$];
	int   mismatch_count;
	int   send_calm;
	int   recv_calm;

	typedef struct {
		sis_pkg::cmd_t   cmd;
		sis_pkg::value_t val;
		bit              typed;
		sis_pkg::rsp_t   rsp;
	} dir_row_t;

	dir_row_t dir_rows [25] = '{
		'{sis_pkg::CMD_FIND,   64'sd0,    1'b1, '{0, 0, 0, 0, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_REMOVE, 64'sd5,    1'b1, '{0, 0, 0, 0, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_ADD,    64'sd0,    1'b1, '{0, 0, 0, 1, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_ADD,    64'sd0,    1'b1, '{1, 0, 0, 1, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_ADD,    V_I16_MAX, 1'b1, '{0, 1, 0, 2, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_ADD,    V_I16_MIN, 1'b1, '{0, 0, 0, 3, sis_pkg::WCLASS_16}},
		'{sis_pkg::CMD_ADD,    64'sd32768, 1'b1, '{0, 3, 0, 4, sis_pkg::WCLASS_32}},
		'{sis_pkg::CMD_ADD,    V_I32_MIN, 1'b1, '{0, 0, 0, 5, sis_pkg::WCLASS_32}},
		'{sis_pkg::CMD_ADD,    64'sd2147483648, 1'b1, '{0, 5, 0, 6, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_ADD,    V_I64_MAX, 1'b1, '{0, 6, 0, 7, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_ADD,    V_I64_MIN, 1'b1, '{0, 0, 0, 8, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_FIND,   V_I64_MAX, 1'b1, '{1, 7, 0, 8, sis_pkg::WCLASS_64}},
		'{CMD_UNUSED,          64'sd0,    1'b1, '{1, 3, 0, 8, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_REMOVE, 64'sd0,    1'b1, '{1, 3, 0, 7, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_REMOVE, 64'sd0,    1'b1, '{0, 3, 0, 7, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_FIND,   -64'sd1,   1'b1, '{0, 3, 0, 7, sis_pkg::WCLASS_64}},
		'{sis_pkg::CMD_ADD,    V_I32_MAX, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I64_MIN, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I64_MAX, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I16_MAX, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I16_MIN, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, 64'sd32768, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I32_MIN, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, V_I32_MAX, 1'b0, '0},
		'{sis_pkg::CMD_REMOVE, 64'sd2147483648, 1'b1, '{1, 0, 0, 0, sis_pkg::WCLASS_16}}
	};

	function automatic sis_pkg::wclass_t narrowest_class(sis_pkg::value_t v);
		if (v >= V_I16_MIN && v <= V_I16_MAX)
			return sis_pkg::WCLASS_16;
		if (v >= V_I32_MIN && v <= V_I32_MAX)
			return sis_pkg::WCLASS_32;
		return sis_pkg::WCLASS_64;
	endfunction

	// Binary search over the shadow set, then apply the command to it.
	function automatic sis_pkg::rsp_t apply_set_command(sis_pkg::cmd_t cmd, sis_pkg::value_t v);
		int unsigned lo, hi, mid, i;
		bit hit;
		sis_pkg::rsp_t r;
		sis_pkg::wclass_t c;
		lo = 0;
		hi = member_count;
		hit = 1'b0;
		while (lo < hi && !hit) begin
			mid = (lo + hi) / 2;
			if (member_vals[mid] == v) begin
				hit = 1'b1;
				lo = mid;
			end else if (member_vals[mid] < v) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		r.present = hit;
		r.position = sis_pkg::pos_t'(lo);
		r.status = 1'b0;
		if (cmd == sis_pkg::CMD_ADD && !hit) begin
			if (member_count >= SET_CAPACITY) begin
				r.status = 1'b1;
			end else begin
				for (i = member_count; i > lo; i--)
					member_vals[i] = member_vals[i - 1];
				member_vals[lo] = v;
				member_count++;
				c = narrowest_class(v);
				if (c > member_class)
					member_class = c;
			end
		end else if (cmd == sis_pkg::CMD_REMOVE && hit) begin
			for (i = lo; i + 1 < member_count; i++)
				member_vals[i] = member_vals[i + 1];
			member_count--;
			if (member_count == 0)
				member_class = sis_pkg::WCLASS_16;
		end
		r.count = sis_pkg::pos_t'(member_count);
		r.width_class = member_class;
		return r;
	endfunction

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int next_send_gap();
		int r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_calm = $urandom_range(10, 30);
			return 0;
		end
		if (r < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic int next_recv_stall();
		int r;
		if (recv_calm > 0) begin
			recv_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			recv_calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 70)
			return 0;
		return idle_len();
	endfunction

	function automatic sis_pkg::cmd_t pick_cmd(int add_pct, int rem_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			return sis_pkg::CMD_ADD;
		if (r < add_pct + rem_pct)
			return sis_pkg::CMD_REMOVE;
		if (r < 96)
			return sis_pkg::CMD_FIND;
		return CMD_UNUSED;
	endfunction

	// Often members or their neighbors, so finds and removes hit often.
	function automatic sis_pkg::value_t pick_value();
		int r;
		sis_pkg::value_t m;
		r = $urandom_range(0, 99);
		m = (member_count > 0) ? member_vals[$urandom_range(0, member_count - 1)] : '0;
		if (r < 45)
			return m;
		if (r < 60)
			return sis_pkg::value_t'($signed(16'($urandom)));
		if (r < 70)
			return sis_pkg::value_t'($signed(32'($urandom)));
		if (r < 85)
			return {$urandom, $urandom};
		if (r < 95) begin
			case ($urandom_range(0, 9))
				0: return V_I16_MAX;
				1: return V_I16_MIN;
				2: return V_I16_MAX + 1;
				3: return V_I16_MIN - 1;
				4: return V_I32_MAX;
				5: return V_I32_MIN;
				6: return V_I32_MAX + 1;
				7: return V_I32_MIN - 1;
				8: return V_I64_MAX;
				default: return V_I64_MIN;
			endcase
		end
		return ($urandom_range(0, 1) != 0) ? m + 1 : m - 1;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Inputs change at the falling edge; valid drops only when a gap follows.
	task automatic send_request(sis_pkg::cmd_t cmd, sis_pkg::value_t val, bit typed,
		sis_pkg::rsp_t typed_rsp);
		int gap;
		sis_pkg::rsp_t predicted;
		gap = next_send_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value   <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_set_command(cmd, val);
		pending_rsp_q.push_back(typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	task automatic hold_until_answered();
		req_ch.valid <= 1'b0;
		wait (pending_rsp_q.size() == 0);
		@(negedge clk);
	endtask

	task automatic run_random(int n, int add_pct, int rem_pct);
		sis_pkg::cmd_t c;
		int k;
		for (k = 0; k < n; k++) begin
			c = pick_cmd(add_pct, rem_pct);
			send_request(c, pick_value(), 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// response sink with random back-pressure
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall = next_recv_stall();
			end
		end
	end

	always @(posedge clk) begin
		sis_pkg::rsp_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.present = rsp_ch.present;
			got.position = rsp_ch.position;
			got.status = rsp_ch.status;
			got.count = rsp_ch.count;
			got.width_class = rsp_ch.width_class;
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_rsp_q.pop_front();
				compare_field("present", got.present, want.present);
				compare_field("position", got.position, want.position);
				compare_field("status", got.status, want.status);
				compare_field("count", got.count, want.count);
				compare_field("width_class", got.width_class, want.width_class);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = sis_pkg::CMD_FIND;
		req_ch.value = '0;
		member_count = 0;
		member_class = sis_pkg::WCLASS_16;
		mismatch_count = 0;
		send_calm = 0;
		recv_calm = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[k])
			send_request(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].rsp);

		run_random(60, 45, 25);
		hold_until_answered();

		// fill the store, then hammer it while full
		while (member_count < SET_CAPACITY) begin
			if ($urandom_range(0, 3) == 0)
				send_request(sis_pkg::CMD_ADD, sis_pkg::value_t'($signed(16'($urandom))),
					1'b0, '0);
			else
				send_request(sis_pkg::CMD_ADD, {$urandom, $urandom}, 1'b0, '0);
		end
		send_request(sis_pkg::CMD_ADD, V_I64_MAX, 1'b0, '0);
		send_request(sis_pkg::CMD_ADD, V_I64_MIN, 1'b0, '0);
		send_request(sis_pkg::CMD_ADD, member_vals[100], 1'b0, '0);
		send_request(sis_pkg::CMD_FIND, member_vals[SET_CAPACITY - 1], 1'b0, '0);
		run_random(40, 60, 15);

		run_random(60, 30, 45);

		req_ch.valid <= 1'b0;
		wait (pending_rsp_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp_q.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_rsp_q.size()));
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/sis_pkg.sv
design/sis_if.sv
design/sis_store.sv
design/sis_ctrl.sv
design/sorted_integer_set.sv
dv/tb_top.sv
